>>> hdl/mhimw_pkg.sv
// Shared types, widths and codes for the invariant mass window block.
// Used by the controller, the datapath and the top level.
package mhimw_pkg;

  // Field and register widths in units of 1/16 MeV.
  localparam int MOM_W      = 25;
  localparam int EN_W       = 25;
  localparam int MASS_CFG_W = 20;
  localparam int MASS_W     = 27;
  localparam int SUM_W      = 28;
  localparam int SLOT_W     = 3;
  localparam int CFG_W      = 27;
  localparam int CFG_IDX_W  = 3;

  // Hypothesis slot registers provided by the register map.
  localparam int CFG_SLOTS     = 4;
  localparam int MAX_SLOTS_DEF = 4;
  localparam int SLOTS_RESET   = 2;

  // Squares and the square root datapath.
  localparam int PROD_W = 2 * SUM_W - 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RAD_W  = 2 * SUM_W;
  localparam int ROOT_W = RAD_W / 2;

  // Sequencing of the four square terms through the shared multiplier.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] SQ_LAST = STEP_W'(4);

  localparam int MASS_MAX_MAG = 2 ** (MASS_W - 1) - 1;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = ((3 * MOM_W + EN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((MASS_W + 7) / 8) * 8;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_MASS_0,
    REG_SLOT_MASS_1,
    REG_SLOT_MASS_2,
    REG_SLOT_MASS_3,
    REG_SLOTS_IN_USE,
    REG_MASS_LOW,
    REG_MASS_HIGH
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DSQ,
    ST_DSTART,
    ST_DROOT,
    ST_DACC,
    ST_MSQ,
    ST_MSTART,
    ST_MROOT,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              sq_run;
    logic [STEP_W-1:0] sq_step;
    logic              cand;
    logic              root_start;
    logic              accum;
    logic              emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_used;
    logic match;
    logic last;
    logic root_busy;
    logic root_done;
    logic out_free;
  } status_t;

endpackage

>>> hdl/mhimw_isqrt.sv
// Iterative integer square root, one root bit per cycle, rounding down.
// Depends on nothing but its parameters.
module mhimw_isqrt #(
  parameter int RAD_W = 56
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RAD_W-1:0]     radicand,
  output logic                 busy,
  output logic                 done,
  output logic [RAD_W/2-1:0]   root
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [CNT_W-1:0]  cnt;

  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              fits;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
    trial  = {root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder, partial root and radicand shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> hdl/mhimw_datapath.sv
// Datapath: configuration registers, input registers, shared squarer, running sums,
// square root unit and output register. Depends on mhimw_pkg and mhimw_isqrt.
module mhimw_datapath #(
  parameter int MAX_SLOTS = mhimw_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [mhimw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mhimw_pkg::CFG_W-1:0]       cfg_data,
  input  logic [mhimw_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                              s_tuser,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mhimw_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                              m_tuser,
  input  mhimw_pkg::cmd_t                   cmd,
  output mhimw_pkg::status_t                status
);
  import mhimw_pkg::*;

  localparam int SLOT_CNT = (MAX_SLOTS < CFG_SLOTS) ? MAX_SLOTS : CFG_SLOTS;

  // Configuration registers.
  logic [MASS_CFG_W-1:0]    slot_mass [SLOT_CNT];
  logic [SLOT_W-1:0]        slots_in_use;
  logic signed [MASS_W-1:0] mass_low;
  logic signed [MASS_W-1:0] mass_high;

  // Registered input item.
  logic signed [MOM_W-1:0] mom_x;
  logic signed [MOM_W-1:0] mom_y;
  logic signed [MOM_W-1:0] mom_z;
  logic [EN_W-1:0]         energy_now;
  logic                    match;
  logic                    last;

  // Running sums and slot count.
  logic signed [SUM_W-1:0] sum_px;
  logic signed [SUM_W-1:0] sum_py;
  logic signed [SUM_W-1:0] sum_pz;
  logic signed [SUM_W-1:0] sum_energy;
  logic [SLOT_W-1:0]       slot_index;

  // Squarer and accumulator.
  logic signed [SUM_W-1:0]   sq_op;
  logic signed [2*SUM_W-1:0] sq_full;
  logic [PROD_W-1:0]         prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_term;
  logic signed [ACC_W-1:0]   acc_negated;
  logic                      acc_add;

  // Square root and result.
  logic [RAD_W-1:0]         rad;
  logic                     root_busy;
  logic                     root_done;
  logic [ROOT_W-1:0]        root;
  logic                     mass_neg;
  logic signed [MASS_W-1:0] mass_val;
  logic                     in_win;
  logic signed [MASS_W-1:0] out_mass;
  logic                     out_win;

  logic [SLOT_W-1:0]     used_n;
  logic [MASS_CFG_W-1:0] slot_m;
  logic [EN_W-1:0]       e_add;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
    logic signed [SUM_W-1:0] r;
    if (v[SUM_W] != v[SUM_W-1]) begin
      r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_CNT; i++) begin
        slot_mass[i] <= '0;
      end
      slots_in_use <= SLOT_W'(SLOTS_RESET);
      mass_low     <= '0;
      mass_high    <= '0;
    end else if (cfg_wen) begin
      for (int i = 0; i < SLOT_CNT; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_SLOT_MASS_0) + CFG_IDX_W'(i)) begin
          slot_mass[i] <= cfg_data[MASS_CFG_W-1:0];
        end
      end
      if (cfg_index == REG_SLOTS_IN_USE) begin
        slots_in_use <= cfg_data[SLOT_W-1:0];
      end
      if (cfg_index == REG_MASS_LOW) begin
        mass_low <= cfg_data[MASS_W-1:0];
      end
      if (cfg_index == REG_MASS_HIGH) begin
        mass_high <= cfg_data[MASS_W-1:0];
      end
    end
  end

  // Number of slots in use and the mass of the current slot.
  always_comb begin
    used_n = (slots_in_use > SLOT_W'(SLOT_CNT)) ? SLOT_W'(SLOT_CNT) : slots_in_use;
    slot_m = '0;
    for (int i = 0; i < SLOT_CNT; i++) begin
      if (slot_index == SLOT_W'(i)) begin
        slot_m = slot_mass[i];
      end
    end
  end

  // Input item register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mom_x      <= s_tdata[MOM_W-1:0];
      mom_y      <= s_tdata[2*MOM_W-1:MOM_W];
      mom_z      <= s_tdata[3*MOM_W-1:2*MOM_W];
      energy_now <= s_tdata[3*MOM_W +: EN_W];
      match      <= s_tuser;
      last       <= s_tlast;
    end
  end

  // Operand of the shared squarer: a daughter's terms or the candidate's sums.
  always_comb begin
    if (cmd.cand) begin
      case (cmd.sq_step[1:0])
        2'd0:    sq_op = sum_energy;
        2'd1:    sq_op = sum_px;
        2'd2:    sq_op = sum_py;
        default: sq_op = sum_pz;
      endcase
    end else begin
      case (cmd.sq_step[1:0])
        2'd0:    sq_op = {{(SUM_W-MOM_W){mom_x[MOM_W-1]}}, mom_x};
        2'd1:    sq_op = {{(SUM_W-MOM_W){mom_y[MOM_W-1]}}, mom_y};
        2'd2:    sq_op = {{(SUM_W-MOM_W){mom_z[MOM_W-1]}}, mom_z};
        default: sq_op = {{(SUM_W-MASS_CFG_W){1'b0}}, slot_m};
      endcase
    end
    sq_full  = sq_op * sq_op;
    acc_term = {2'b00, prod};
    // Energy squared is added; momentum squares of the candidate are subtracted.
    acc_add  = !cmd.cand || (cmd.sq_step == STEP_W'(1));
  end

  // Product register one step ahead of the accumulator.
  always_ff @(posedge clk) begin
    if (cmd.sq_run) begin
      if (cmd.sq_step != SQ_LAST) begin
        prod <= sq_full[PROD_W-1:0];
      end
      if (cmd.sq_step == '0) begin
        acc <= '0;
      end else if (acc_add) begin
        acc <= acc + acc_term;
      end else begin
        acc <= acc - acc_term;
      end
    end
  end

  // Magnitude of the accumulated value feeds the square root.
  always_comb begin
    acc_negated = -acc;
    rad = acc[ACC_W-1] ? acc_negated[RAD_W-1:0] : acc[RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      mass_neg <= acc[ACC_W-1];
    end
  end

  mhimw_isqrt #(
    .RAD_W (RAD_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (rad),
    .busy     (root_busy),
    .done     (root_done),
    .root     (root)
  );

  // Running sums with saturation; cleared when the candidate is emitted.
  always_comb begin
    e_add = match ? energy_now : root[EN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      sum_px     <= '0;
      sum_py     <= '0;
      sum_pz     <= '0;
      sum_energy <= '0;
      slot_index <= '0;
    end else if (cmd.accum) begin
      sum_px     <= sat_sum({sum_px[SUM_W-1], sum_px}
                    + {{(SUM_W-MOM_W+1){mom_x[MOM_W-1]}}, mom_x});
      sum_py     <= sat_sum({sum_py[SUM_W-1], sum_py}
                    + {{(SUM_W-MOM_W+1){mom_y[MOM_W-1]}}, mom_y});
      sum_pz     <= sat_sum({sum_pz[SUM_W-1], sum_pz}
                    + {{(SUM_W-MOM_W+1){mom_z[MOM_W-1]}}, mom_z});
      sum_energy <= sat_sum({sum_energy[SUM_W-1], sum_energy}
                    + {{(SUM_W-EN_W+1){1'b0}}, e_add});
      slot_index <= slot_index + 1'b1;
    end
  end

  // Signed, saturated mass and the window test.
  always_comb begin
    if (mass_neg) begin
      if (root > ROOT_W'(MASS_MAX_MAG + 1)) begin
        mass_val = {1'b1, {(MASS_W-1){1'b0}}};
      end else begin
        mass_val = -root[MASS_W-1:0];
      end
    end else begin
      if (root > ROOT_W'(MASS_MAX_MAG)) begin
        mass_val = {1'b0, {(MASS_W-1){1'b1}}};
      end else begin
        mass_val = root[MASS_W-1:0];
      end
    end
    in_win = (mass_val > mass_low) && (mass_val < mass_high);
  end

  // Output register: holds the result item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_mass <= mass_val;
      out_win  <= in_win;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-MASS_W){1'b0}}, out_mass};
  assign m_tuser = out_win;

  always_comb begin
    status.slot_used = (slot_index < used_n);
    status.match     = match;
    status.last      = last;
    status.root_busy = root_busy;
    status.root_done = root_done;
    status.out_free  = !m_tvalid || m_tready;
  end

`ifndef NO_ASSERTIONS
  // A daughter's radicand is a sum of squares and never negative.
  a_daughter_rad_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.root_start && !cmd.cand |-> !acc[ACC_W-1])
    else $error("daughter radicand negative");

  // The slot count saturates at the number of hypothesis slots.
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_index <= SLOT_W'(SLOT_CNT))
    else $error("slot index beyond slot count");

  // Only daughters within the used slots enter the sums.
  a_accum_used: assert property (@(posedge clk) disable iff (rst)
    cmd.accum |-> status.slot_used)
    else $error("sum updated for a skipped daughter");
`endif

endmodule

>>> hdl/mhimw_ctrl.sv
// Controller state machine: sequences load, squares, square roots, sums and emit.
// Depends on mhimw_pkg; drives the datapath through cmd_t and reads status_t.
module mhimw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  mhimw_pkg::status_t status,
  output mhimw_pkg::cmd_t    cmd
);
  import mhimw_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Square step counter runs only in the squaring states.
  always_comb begin
    if ((state == ST_DSQ || state == ST_MSQ) && step != SQ_LAST) begin
      step_next = step + 1'b1;
    end else begin
      step_next = '0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status.slot_used) begin
          state_next = status.last ? ST_MSQ : ST_IDLE;
        end else if (status.match) begin
          state_next = ST_DACC;
        end else begin
          state_next = ST_DSQ;
        end
      end
      ST_DSQ: begin
        if (step == SQ_LAST) state_next = ST_DSTART;
      end
      ST_DSTART: state_next = ST_DROOT;
      ST_DROOT: begin
        if (status.root_done) state_next = ST_DACC;
      end
      ST_DACC: begin
        state_next = status.last ? ST_MSQ : ST_IDLE;
      end
      ST_MSQ: begin
        if (step == SQ_LAST) state_next = ST_MSTART;
      end
      ST_MSTART: state_next = ST_MROOT;
      ST_MROOT: begin
        if (status.root_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DSQ: begin
        cmd.sq_run  = 1'b1;
        cmd.sq_step = step;
      end
      ST_DSTART: cmd.root_start = 1'b1;
      ST_DACC:   cmd.accum = 1'b1;
      ST_MSQ: begin
        cmd.sq_run  = 1'b1;
        cmd.sq_step = step;
        cmd.cand    = 1'b1;
      end
      ST_MSTART: begin
        cmd.root_start = 1'b1;
        cmd.cand       = 1'b1;
      end
      ST_FIN: cmd.emit = status.out_free;
      default: cmd = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  // The square root unit is never restarted while it is working.
  a_root_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.root_start |-> !status.root_busy)
    else $error("square root restarted while busy");

  // A finished root arrives only while the controller waits for it.
  a_root_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.root_done |-> (state == ST_DROOT || state == ST_MROOT))
    else $error("square root finished outside a wait state");
`endif

endmodule

>>> hdl/mass_hypothesis_invariant_mass_window_core.sv
// Top level of the invariant mass window block with mass hypothesis substitution.
// Depends on mhimw_pkg, mhimw_ctrl and mhimw_datapath.
//
//   Channel   Direction  Handshake                Payload
//   s_axis    in         tvalid/tready            daughter momentum, energy, flags
//   m_axis    out        tvalid/tready            invariant mass and window flag
//   cfg       in         cfg_wen, write only      slot masses, slot count, window
//
// A daughter that keeps its energy passes only through the check and accumulate states;
// one whose energy is recomputed also runs its squares and the square root unit, which
// yields one root bit per cycle. The last daughter adds the candidate's squares and
// mass root. Reset is synchronous and clears control state, configuration and sums.
// A waiting result sits in the output register; the next item is taken meanwhile,
// and the block stalls only when a new result is ready before the last one is taken.
module mass_hypothesis_invariant_mass_window_core #(
  parameter int MAX_SLOTS = mhimw_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // mom_x [24:0], mom_y [49:25], mom_z [74:50], energy_now [99:75], zero fill
  input  logic [mhimw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // already_matches
  input  logic                              s_axis_tuser,
  // last_daughter
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // inv_mass [26:0], zero fill
  output logic [mhimw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // in_window
  output logic                              m_axis_tuser,
  input  logic                              cfg_wen,
  input  logic [mhimw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mhimw_pkg::CFG_W-1:0]       cfg_data
);
  import mhimw_pkg::*;

  cmd_t    cmd;
  status_t status;

  mhimw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mhimw_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .s_tlast   (s_axis_tlast),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata),
    .m_tuser   (m_axis_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
